>>> rtl/core/cap_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cap_pkg
// Types and codes shared by the command frame parser modules.
// ----------------------------------------------------------------------------
package cap_pkg;

    localparam int BYTE_W  = 8;
    localparam int ERR_W   = 3;
    localparam int LC_W    = 16;
    localparam int LE_W    = 17;
    localparam int TDATA_W = 80;

    // error codes reported on the closing beat of a frame
    localparam logic [ERR_W-1:0] ERR_NONE         = 3'd0;
    localparam logic [ERR_W-1:0] ERR_SHORT_HEADER = 3'd1;
    localparam logic [ERR_W-1:0] ERR_TRUNC_LENGTH = 3'd2;
    localparam logic [ERR_W-1:0] ERR_TRUNC_DATA   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_LENGTH_WIDE  = 3'd4;
    localparam logic [ERR_W-1:0] ERR_LE_WIDE      = 3'd5;

    localparam logic [BYTE_W-1:0] EXT_LEN_FLAG = 8'h80;
    localparam logic [LE_W-1:0]   LE_SHORT_MAX = 17'd256;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              last;
    } cap_beat_t;

    typedef struct packed {
        logic              data_valid;
        logic [BYTE_W-1:0] data_byte;
        logic              done_res;
        logic [ERR_W-1:0]  error_code;
        logic [BYTE_W-1:0] cla;
        logic [BYTE_W-1:0] ins;
        logic [BYTE_W-1:0] p1;
        logic [BYTE_W-1:0] p2;
        logic [LC_W-1:0]   lc;
        logic [LE_W-1:0]   le;
    } cap_result_t;

endpackage
`default_nettype wire

>>> rtl/core/cap_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cap_in_stage
// Input register: holds one incoming beat until the parser consumes it.
// ----------------------------------------------------------------------------
module cap_in_stage
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire cap_pkg::cap_beat_t in_beat,
    input  wire logic              consume,
    output logic                   beat_valid,
    output cap_pkg::cap_beat_t     beat
);
    import cap_pkg::*;

    logic      valid_reg;
    cap_beat_t beat_reg;
    logic      take;

    // a beat may enter in the same cycle the held one is consumed
    assign in_ready   = !valid_reg || consume;
    assign take       = in_valid && in_ready;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            beat_reg <= in_beat;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/cap_frame_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cap_frame_fsm
// Frame state and the per-byte parse step: header, length, body and Le.
// ----------------------------------------------------------------------------
module cap_frame_fsm
#(
    parameter int MAX_LENGTH_BYTES = 2,
    parameter int MAX_EXPECT_BYTES = 2
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire cap_pkg::cap_beat_t  beat,
    output logic                     produce,
    output cap_pkg::cap_result_t     result
);
    import cap_pkg::*;

    localparam int LEFT_W = $clog2(MAX_LENGTH_BYTES + 1);
    localparam int SEEN_W = $clog2(MAX_EXPECT_BYTES + 1);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_EXTLEN,
        PH_DATA,
        PH_EXPECT,
        PH_SKIP
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [LC_W-1:0]     count_reg, count_next;
    logic [BYTE_W-1:0]   hdr_reg [4];
    logic [BYTE_W-1:0]   hdr_next [4];
    logic [BYTE_W-1:0]   hdr_upd [4];
    logic [LC_W-1:0]     len_reg, len_next;
    logic [LEFT_W-1:0]   left_reg, left_next;
    logic [LC_W-1:0]     exp_reg, exp_next;
    logic [SEEN_W-1:0]   seen_reg, seen_next;
    logic [ERR_W-1:0]    perr_reg, perr_next;

    logic                dv;
    logic                done;
    logic [ERR_W-1:0]    err;
    logic [LC_W-1:0]     lc_val;
    logic [LE_W-1:0]     le_val;
    logic                do_finish;
    logic                do_raise;
    logic [ERR_W-1:0]    raise_code;
    logic [LC_W-1:0]     len_val;
    logic [LC_W-1:0]     exp_val;
    logic [LC_W-1:0]     count_inc;
    logic [LEFT_W-1:0]   left_dec;
    logic [6:0]          ext_count;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        hdr_upd    = hdr_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        exp_next   = exp_reg;
        seen_next  = seen_reg;
        perr_next  = perr_reg;
        dv         = 1'b0;
        done       = 1'b0;
        err        = ERR_NONE;
        lc_val     = '0;
        le_val     = '0;
        do_finish  = 1'b0;
        do_raise   = 1'b0;
        raise_code = ERR_NONE;
        len_val    = len_reg;
        exp_val    = exp_reg;
        count_inc  = count_reg + LC_W'(1);
        left_dec   = '0;
        ext_count  = beat.in_byte[6:0];

        unique case (phase_reg)
            PH_HEADER:
            begin
                hdr_upd[count_reg[1:0]] = beat.in_byte;
                if (count_reg[1:0] == 2'd3)
                begin
                    count_next = '0;
                    phase_next = PH_LENGTH;
                    done       = beat.last;
                end
                else
                begin
                    count_next = count_inc;
                    if (beat.last)
                    begin
                        done = 1'b1;
                        err  = ERR_SHORT_HEADER;
                    end
                end
            end
            PH_LENGTH:
            begin
                if ((beat.in_byte & EXT_LEN_FLAG) != '0)
                begin
                    len_val  = '0;
                    len_next = '0;
                    if (ext_count > 7'(MAX_LENGTH_BYTES))
                    begin
                        do_raise   = 1'b1;
                        raise_code = ERR_LENGTH_WIDE;
                    end
                    else if (ext_count == 7'd0)
                    begin
                        do_finish = 1'b1;
                    end
                    else
                    begin
                        left_next = ext_count[LEFT_W-1:0];
                        if (beat.last)
                        begin
                            done = 1'b1;
                            err  = ERR_TRUNC_LENGTH;
                        end
                        else
                        begin
                            phase_next = PH_EXTLEN;
                        end
                    end
                end
                else
                begin
                    len_val   = {8'd0, beat.in_byte};
                    len_next  = len_val;
                    do_finish = 1'b1;
                end
            end
            PH_EXTLEN:
            begin
                // another byte would not fit the 16-bit length
                if (len_reg[15:8] != '0)
                begin
                    do_raise   = 1'b1;
                    raise_code = ERR_LENGTH_WIDE;
                end
                else
                begin
                    len_val   = {len_reg[7:0], beat.in_byte};
                    len_next  = len_val;
                    left_dec  = (left_reg != '0) ? left_reg - LEFT_W'(1) : '0;
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        do_finish = 1'b1;
                    end
                    else if (beat.last)
                    begin
                        done = 1'b1;
                        err  = ERR_TRUNC_LENGTH;
                    end
                end
            end
            PH_DATA:
            begin
                dv         = 1'b1;
                count_next = count_inc;
                if (count_inc >= len_reg)
                begin
                    if (beat.last)
                    begin
                        done   = 1'b1;
                        lc_val = len_reg;
                    end
                    else
                    begin
                        exp_next   = '0;
                        seen_next  = '0;
                        phase_next = PH_EXPECT;
                    end
                end
                else if (beat.last)
                begin
                    done = 1'b1;
                    err  = ERR_TRUNC_DATA;
                end
            end
            PH_EXPECT:
            begin
                if (seen_reg == SEEN_W'(MAX_EXPECT_BYTES) ||
                    (seen_reg != '0 && exp_reg[15:8] != '0))
                begin
                    do_raise   = 1'b1;
                    raise_code = ERR_LE_WIDE;
                end
                else
                begin
                    exp_val   = (seen_reg != '0) ? {exp_reg[7:0], beat.in_byte}
                                                 : {8'd0, beat.in_byte};
                    exp_next  = exp_val;
                    seen_next = seen_reg + SEEN_W'(1);
                    if (beat.last)
                    begin
                        done   = 1'b1;
                        lc_val = len_reg;
                        // a single zero byte asks for the short maximum
                        le_val = (seen_reg == '0 && exp_val == '0) ? LE_SHORT_MAX
                                                                  : {1'b0, exp_val};
                    end
                end
            end
            PH_SKIP:
            begin
                if (beat.last)
                begin
                    done = 1'b1;
                    err  = perr_reg;
                end
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase

        if (do_finish)
        begin
            if (beat.last)
            begin
                done   = 1'b1;
                le_val = {1'b0, len_val};
            end
            else
            begin
                count_next = '0;
                exp_next   = '0;
                seen_next  = '0;
                phase_next = (len_val != '0) ? PH_DATA : PH_EXPECT;
            end
        end

        if (do_raise)
        begin
            if (beat.last)
            begin
                done = 1'b1;
                err  = raise_code;
            end
            else
            begin
                perr_next  = raise_code;
                phase_next = PH_SKIP;
            end
        end

        hdr_next = hdr_upd;

        // close the frame: clear everything for the next one
        if (done)
        begin
            phase_next = PH_HEADER;
            count_next = '0;
            hdr_next   = '{default: '0};
            len_next   = '0;
            left_next  = '0;
            exp_next   = '0;
            seen_next  = '0;
            perr_next  = ERR_NONE;
        end
    end

    always_comb
    begin
        produce           = dv || done;
        result.data_valid = dv;
        result.data_byte  = dv ? beat.in_byte : '0;
        result.done_res   = done;
        result.error_code = done ? err : ERR_NONE;
        result.cla        = done ? hdr_upd[0] : '0;
        result.ins        = done ? hdr_upd[1] : '0;
        result.p1         = done ? hdr_upd[2] : '0;
        result.p2         = done ? hdr_upd[3] : '0;
        result.lc         = (done && err == ERR_NONE) ? lc_val : '0;
        result.le         = (done && err == ERR_NONE) ? le_val : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            count_reg <= '0;
            hdr_reg   <= '{default: '0};
            len_reg   <= '0;
            left_reg  <= '0;
            exp_reg   <= '0;
            seen_reg  <= '0;
            perr_reg  <= ERR_NONE;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            hdr_reg   <= hdr_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            exp_reg   <= exp_next;
            seen_reg  <= seen_next;
            perr_reg  <= perr_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/cap_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cap_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module cap_out_stage
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire cap_pkg::cap_result_t result,
    output logic                      space,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output cap_pkg::cap_result_t      out_result
);
    import cap_pkg::*;

    logic        valid_reg;
    cap_result_t result_reg;

    assign space      = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/command_apdu_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// command_apdu_parser_unit
// Smart-card command frame parser: header, Lc, body pass-through and Le.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                          | tuser      | tlast
//  s_axis  | in  | frame byte                     | -          | last byte
//  m_axis  | out | body byte, error, header, Lc/Le| data_valid | frame done
//
//  One byte per cycle sustained while m_axis takes results; a taken beat waits
//  in the input register, and its result then loads into the result register.
//  Bytes that give no result (header, length, Le) need no result slot.
//  rst_n clears the frame state; the next beat starts a fresh header.
//  A stalled m_axis holds the result; s_axis stalls only when a held beat
//  needs the result slot.
// ----------------------------------------------------------------------------
module command_apdu_parser_unit
#(
    parameter int MAX_LENGTH_BYTES = 2,
    parameter int MAX_EXPECT_BYTES = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,   // last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [cap_pkg::TDATA_W-1:0] m_axis_tdata, // data_byte, error_code, cla, ins,
                                                      // p1, p2, lc, le
    output logic             m_axis_tuser,   // data_valid
    output logic             m_axis_tlast    // done_res
);
    import cap_pkg::*;

    cap_beat_t   in_beat;
    cap_beat_t   beat;
    logic        beat_valid;
    logic        consume;
    logic        produce;
    logic        space;
    cap_result_t result;
    cap_result_t out_result;

    assign in_beat.in_byte = s_axis_tdata;
    assign in_beat.last    = s_axis_tlast;

    // advance a held beat when its result, if any, has somewhere to go
    assign consume = beat_valid && (!produce || space);

    cap_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_beat    (in_beat),
        .consume    (consume),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    cap_frame_fsm
    #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES),
        .MAX_EXPECT_BYTES (MAX_EXPECT_BYTES)
    )
    u_fsm
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (consume),
        .beat    (beat),
        .produce (produce),
        .result  (result)
    );

    cap_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (consume && produce),
        .result     (result),
        .space      (space),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    assign m_axis_tdata = {4'd0,
                           out_result.le,
                           out_result.lc,
                           out_result.p2,
                           out_result.p1,
                           out_result.ins,
                           out_result.cla,
                           out_result.error_code,
                           out_result.data_byte};
    assign m_axis_tuser = out_result.data_valid;
    assign m_axis_tlast = out_result.done_res;

endmodule
`default_nettype wire

>>> dv/tb_command_apdu_parser_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_command_apdu_parser_unit
// Streams command frames byte by byte into the parser and predicts every
// body byte and every closing beat from a behavioural copy of the parser.
// Directed frames come first, then random frames, most of them
// well-formed, with the rest truncated, overlong, too wide in length count or pure noise.
// Both stream sides idle at random. One long output stall is forced so that
// the input backs up, and the sender also pauses until every result is in.
// ----------------------------------------------------------------------------

typedef enum logic [2:0] {
    ST_HEADER,
    ST_LENGTH,
    ST_EXT_LEN,
    ST_BODY,
    ST_LE,
    ST_DISCARD
} parse_step_e;

class apdu_result_book;

    localparam int LEN_BYTES_MAX = 2;
    localparam int LE_BYTES_MAX  = 2;

    cap_pkg::cap_result_t awaited[$];
    int unsigned          fails = 0;

    parse_step_e step;
    logic [15:0] cnt;
    logic [7:0]  hdr [4];
    logic [15:0] len_acc;
    int unsigned len_left;
    logic [16:0] le_acc;
    int unsigned le_seen;
    logic [2:0]  held_err;

    // outcome of the beat being predicted
    logic        fin;
    logic [2:0]  fin_err;
    logic [15:0] fin_lc;
    logic [16:0] fin_le;

    function new();
        clear_frame();
    endfunction

    function void clear_frame();
        step     = ST_HEADER;
        cnt      = '0;
        for (int i = 0; i < 4; i++)
            hdr[i] = '0;
        len_acc  = '0;
        len_left = 0;
        le_acc   = '0;
        le_seen  = 0;
        held_err = cap_pkg::ERR_NONE;
    endfunction

    // close now on the last byte, otherwise drop bytes until it comes
    function void flag_error(logic [2:0] code, logic is_last);
        if (is_last)
        begin
            fin     = 1'b1;
            fin_err = code;
        end
        else
        begin
            held_err = code;
            step     = ST_DISCARD;
        end
    endfunction

    function void close_length(logic is_last);
        if (is_last)
        begin
            fin    = 1'b1;
            fin_lc = '0;
            fin_le = {1'b0, len_acc};
        end
        else
        begin
            cnt     = '0;
            le_acc  = '0;
            le_seen = 0;
            step    = (len_acc != 0) ? ST_BODY : ST_LE;
        end
    endfunction

    function void take_byte(logic [7:0] b, logic is_last);
        cap_pkg::cap_result_t r;
        logic                 dv;
        int unsigned          n;

        dv      = 1'b0;
        fin     = 1'b0;
        fin_err = cap_pkg::ERR_NONE;
        fin_lc  = '0;
        fin_le  = '0;

        case (step)
            ST_HEADER:
            begin
                hdr[cnt[1:0]] = b;
                cnt = cnt + 16'd1;
                if (cnt >= 4)
                begin
                    cnt  = '0;
                    step = ST_LENGTH;
                    if (is_last)
                        fin = 1'b1;
                end
                else if (is_last)
                begin
                    fin     = 1'b1;
                    fin_err = cap_pkg::ERR_SHORT_HEADER;
                end
            end
            ST_LENGTH:
            begin
                if ((b & cap_pkg::EXT_LEN_FLAG) != 0)
                begin
                    n       = b[6:0];
                    len_acc = '0;
                    if (n > LEN_BYTES_MAX)
                        flag_error(cap_pkg::ERR_LENGTH_WIDE, is_last);
                    else if (n == 0)
                        close_length(is_last);
                    else
                    begin
                        len_left = n;
                        if (is_last)
                        begin
                            fin     = 1'b1;
                            fin_err = cap_pkg::ERR_TRUNC_LENGTH;
                        end
                        else
                            step = ST_EXT_LEN;
                    end
                end
                else
                begin
                    len_acc = {8'h00, b};
                    close_length(is_last);
                end
            end
            ST_EXT_LEN:
            begin
                if (len_acc > 16'h00FF)
                    flag_error(cap_pkg::ERR_LENGTH_WIDE, is_last);
                else
                begin
                    len_acc = {len_acc[7:0], b};
                    if (len_left > 0)
                        len_left--;
                    if (len_left == 0)
                        close_length(is_last);
                    else if (is_last)
                    begin
                        fin     = 1'b1;
                        fin_err = cap_pkg::ERR_TRUNC_LENGTH;
                    end
                end
            end
            ST_BODY:
            begin
                dv  = 1'b1;
                cnt = cnt + 16'd1;
                if (cnt >= len_acc)
                begin
                    if (is_last)
                    begin
                        fin    = 1'b1;
                        fin_lc = len_acc;
                    end
                    else
                    begin
                        le_acc  = '0;
                        le_seen = 0;
                        step    = ST_LE;
                    end
                end
                else if (is_last)
                begin
                    fin     = 1'b1;
                    fin_err = cap_pkg::ERR_TRUNC_DATA;
                end
            end
            ST_LE:
            begin
                if (le_seen >= LE_BYTES_MAX || (le_seen > 0 && le_acc > 17'h000FF))
                    flag_error(cap_pkg::ERR_LE_WIDE, is_last);
                else
                begin
                    le_acc = (le_seen != 0) ? {le_acc[8:0], b} : {9'd0, b};
                    le_seen++;
                    if (is_last)
                    begin
                        fin    = 1'b1;
                        fin_lc = len_acc;
                        fin_le = (le_seen == 1 && le_acc == 0) ? cap_pkg::LE_SHORT_MAX
                                                               : le_acc;
                    end
                end
            end
            default:
            begin
                if (is_last)
                begin
                    fin     = 1'b1;
                    fin_err = held_err;
                end
            end
        endcase

        if (!dv && !fin)
            return;

        r            = '0;
        r.data_valid = dv;
        r.data_byte  = dv ? b : 8'h00;
        r.done_res   = fin;
        if (fin)
        begin
            r.error_code = fin_err;
            r.cla        = hdr[0];
            r.ins        = hdr[1];
            r.p1         = hdr[2];
            r.p2         = hdr[3];
            r.lc         = (fin_err != cap_pkg::ERR_NONE) ? 16'd0 : fin_lc;
            r.le         = (fin_err != cap_pkg::ERR_NONE) ? 17'd0 : fin_le;
            clear_frame();
        end
        awaited.push_back(r);
    endfunction

    function void cmp(string what, logic [16:0] want, logic [16:0] got);
        if (want !== got)
        begin
            fails++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    function void match_result(logic [79:0] td, logic tuser, logic tlast);
        cap_pkg::cap_result_t want;

        if (awaited.size() == 0)
        begin
            fails++;
            $display("%0t: unexpected result, expected none, got tdata %h tuser %b tlast %b",
                     $time, td, tuser, tlast);
            return;
        end
        want = awaited.pop_front();
        cmp("data_valid", want.data_valid, tuser);
        cmp("data_byte",  want.data_byte,  td[7:0]);
        cmp("done_res",   want.done_res,   tlast);
        cmp("error_code", want.error_code, td[10:8]);
        cmp("cla",        want.cla,        td[18:11]);
        cmp("ins",        want.ins,        td[26:19]);
        cmp("p1",         want.p1,         td[34:27]);
        cmp("p2",         want.p2,         td[42:35]);
        cmp("lc",         want.lc,         td[58:43]);
        cmp("le",         want.le,         td[75:59]);
    endfunction

endclass

module tb_command_apdu_parser_unit;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    apdu_result_book book = new();

    logic [7:0]  frame[$];
    bit          src_calm = 1'b1;
    bit          sink_calm = 1'b0;
    bit          sink_hold = 1'b0;
    int unsigned rand_bytes = 0;
    int unsigned frames_sent = 0;

    command_apdu_parser_unit #(
        .MAX_LENGTH_BYTES(2),
        .MAX_EXPECT_BYTES(2)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;

        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_lc(int unsigned cap);
        int unsigned r;
        int unsigned v;

        r = $urandom_range(0, 99);
        if (r < 10)
            v = 0;
        else if (r < 70)
            v = $urandom_range(1, 6);
        else if (r < 98)
            v = $urandom_range(7, 40);
        else
            v = $urandom_range(200, 260);
        return (v > cap) ? cap[15:0] : v[15:0];
    endfunction

    function automatic logic [7:0] pick_le_byte();
        return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int unsigned stall_left;
        int unsigned cyc;

        stall_left = 0;
        cyc = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 150 == 0)
                sink_calm = ($urandom_range(0, 3) == 0);
            if (sink_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
                sink_hold = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap(sink_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            book.match_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    task automatic send_beat(logic [7:0] b, logic is_last);
        int unsigned gap;

        gap = pick_gap(src_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        book.take_byte(b, is_last);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_beat(frame[i], i == frame.size() - 1);
    endtask

    // drop the offer so the last beat is not taken again while waiting
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (book.awaited.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_header();
        frame.delete();
        repeat (4) frame.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_wellformed(int unsigned body_len);
        int unsigned form;
        int unsigned k;
        logic [15:0] lc;

        add_header();
        form = (body_len > 0) ? 2 : $urandom_range(0, 3);
        lc = '0;
        case (form)
            0: return;
            3:
            begin
                frame.push_back(8'($urandom_range(0, 255)));
                return;
            end
            1:
            begin
                lc = pick_lc(127);
                frame.push_back(lc[7:0]);
            end
            default:
            begin
                k = (body_len > 0) ? 2 : $urandom_range(0, 2);
                frame.push_back(cap_pkg::EXT_LEN_FLAG | 8'(k));
                if (k == 1)
                begin
                    lc = pick_lc(255);
                    frame.push_back(lc[7:0]);
                end
                else if (k == 2)
                begin
                    lc = (body_len > 0) ? body_len[15:0] : pick_lc(65535);
                    frame.push_back(lc[15:8]);
                    frame.push_back(lc[7:0]);
                end
            end
        endcase
        repeat (lc) frame.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2)) frame.push_back(pick_le_byte());
    endtask

    task automatic build_frame();
        int unsigned r;
        int unsigned keep;

        r = $urandom_range(0, 99);
        if (r < 60)
            add_wellformed(0);
        else if (r < 73)
        begin
            // cut short somewhere
            add_wellformed(0);
            keep = $urandom_range(1, frame.size());
            while (frame.size() > keep)
                frame.delete(frame.size() - 1);
        end
        else if (r < 80)
        begin
            // overlong tail
            add_wellformed(0);
            repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 86)
        begin
            add_header();
            frame.push_back(cap_pkg::EXT_LEN_FLAG | 8'($urandom_range(3, 127)));
            repeat ($urandom_range(0, 5)) frame.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            frame.delete();
            repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short header, header only, end on length, wide length count,
        // extended length of zero with Le of 256, truncated body
        src_calm = 1'b1;
        frame = '{8'hA0};
        send_frame();
        frame = '{8'h00, 8'hFF, 8'h00, 8'hFF};
        send_frame();
        frame = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h05};
        send_frame();
        frame = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h83};
        send_frame();
        frame = '{8'hFF, 8'h80, 8'h7F, 8'h01, 8'h80, 8'h00};
        send_frame();
        frame = '{8'hC0, 8'hA4, 8'h04, 8'h00, 8'h03, 8'hAA};
        send_frame();

        // back-pressure: long output stall while a body keeps coming
        sink_hold = 1'b1;
        add_wellformed(40);
        send_frame();
        wait_drained();

        while (rand_bytes < 1150)
        begin
            build_frame();
            src_calm = ($urandom_range(0, 3) == 0);
            send_frame();
            rand_bytes += frame.size();
            frames_sent++;
            if (frames_sent % 25 == 0)
                wait_drained();
        end
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        if (book.fails == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
